[rtl/core/assert_macros.svh]
// Assertion helpers included by the counter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/cdcb_pkg.sv]
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared types, constants and small functions for the date counter.
// ----------------------------------------------------------------------------
package cdcb_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    localparam logic [YEAR_W-1:0]  YEAR_LAST   = 14'd9999;
    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2022;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    function automatic logic [DAY_W-1:0] month_length(
        input logic [YEAR_W-1:0]  year,
        input logic [MONTH_W-1:0] month
    );
        logic [DAY_W-1:0] lim;
        case (month)
            4'd2:    lim = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            4'd4:    lim = 5'd30;
            4'd6:    lim = 5'd30;
            4'd9:    lim = 5'd30;
            4'd11:   lim = 5'd30;
            default: lim = 5'd31;
        endcase
        return lim;
    endfunction

    // Quotient by ten for values up to 99.
    function automatic logic [3:0] div10_99(input logic [6:0] x);
        logic [14:0] prod;
        prod = 15'(x) * 15'd205;
        return prod[14:11];
    endfunction

endpackage

[rtl/core/cdcb_date_next.sv]
// ----------------------------------------------------------------------------
// Calendar date next-state logic
// Computes the date after a one-day tick or after a checked load.
// ----------------------------------------------------------------------------
module cdcb_date_next
    import cdcb_pkg::*;
(
    input  date_t              cur,
    input  logic               operation,
    input  logic [YEAR_W-1:0]  load_year,
    input  logic [MONTH_W-1:0] load_month,
    input  logic [DAY_W-1:0]   load_day,
    output date_t              nxt
);

    logic [YEAR_W-1:0]  ld_year;
    logic [MONTH_W-1:0] ld_month;
    logic [DAY_W-1:0]   ld_lim;
    logic [DAY_W-1:0]   cur_lim;
    date_t              tick_date;
    date_t              load_date;

    always_comb
    begin
        ld_year  = (load_year > YEAR_LAST) ? YEAR_LAST : load_year;
        ld_month = (load_month == 4'd0 || load_month > MONTH_LAST) ? 4'd1 : load_month;
        ld_lim   = month_length(ld_year, ld_month);
        load_date.year  = ld_year;
        load_date.month = ld_month;
        load_date.day   = (load_day == 5'd0 || load_day > ld_lim) ? 5'd1 : load_day;
    end

    always_comb
    begin
        cur_lim   = month_length(cur.year, cur.month);
        tick_date = cur;
        if (cur.day >= cur_lim)
        begin
            tick_date.day = 5'd1;
            if (cur.month >= MONTH_LAST)
            begin
                tick_date.month = 4'd1;
                tick_date.year  = (cur.year >= YEAR_LAST) ? 14'd0 : cur.year + 14'd1;
            end
            else
            begin
                tick_date.month = cur.month + 4'd1;
            end
        end
        else
        begin
            tick_date.day = cur.day + 5'd1;
        end
    end

    assign nxt = (operation == OP_LOAD) ? load_date : tick_date;

endmodule

[rtl/core/calendar_date_counter_bcd_core.sv]
// ----------------------------------------------------------------------------
// Calendar date counter with BCD read-out
// Holds a year, month and day, steps or loads it, and reports the date with
// its eight decimal digits.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction on s_* carries the operation in s_tuser (tick one day
// or load a date) and the load fields in s_tdata. Each input transaction
// produces exactly one output transaction on m_* with the date after the
// step and its digits YYYYMMDD.
// The date register updates in the cycle the input transaction is taken.
// The result leaves through a three-stage pipeline:
// the date register, a stage that divides the year by one hundred, and the
// output register that splits the two halves into digits.
// One transaction per cycle is sustained while m_tready is high; each stage
// holds a valid bit, so input is still taken while a result waits, until all
// stages are full. When the receiver stalls, the output register holds and
// the pipeline fills up, after which s_tready drops.
// Reset sets the date to year 2022, month 1, day 1, and empties the pipeline.
// ----------------------------------------------------------------------------
module calendar_date_counter_bcd_core
    import cdcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: load_year[13:0], load_month[17:14], load_day[22:18], zeros
    input  logic [23:0] s_tdata,
    // s_tuser: operation
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: year_now[13:0], month_now[17:14], day_now[22:18],
    // digit_year_thousands[26:23], digit_year_hundreds[30:27],
    // digit_year_tens[34:31], digit_year_ones[38:35], digit_month_tens[39],
    // digit_month_ones[43:40], digit_day_tens[45:44], digit_day_ones[49:46], zeros
    output logic [55:0] m_tdata
);

`include "assert_macros.svh"

    date_t       date_reg;
    date_t       date_next;
    logic        v1_reg;
    logic        v2_reg;
    logic        vo_reg;
    logic        ready1;
    logic        ready2;
    logic        ready3;
    logic        s_fire;

    date_t       s2_date_reg;
    logic [6:0]  s2_q100_reg;
    logic [26:0] q100_prod;
    logic        s2_mt_reg;
    logic [3:0]  s2_mo_reg;
    logic [1:0]  s2_dt_reg;
    logic [3:0]  s2_do_reg;
    logic        mt_next;
    logic [3:0]  mo_next;
    logic [1:0]  dt_next;
    logic [3:0]  do_next;

    date_t       o_date_reg;
    logic [3:0]  o_yth_reg;
    logic [3:0]  o_yh_reg;
    logic [3:0]  o_yt_reg;
    logic [3:0]  o_yo_reg;
    logic        o_mt_reg;
    logic [3:0]  o_mo_reg;
    logic [1:0]  o_dt_reg;
    logic [3:0]  o_do_reg;
    logic [13:0] lo_diff;
    logic [6:0]  lo_next;
    logic [3:0]  yt_next;
    logic [3:0]  yth_next;

    assign ready3   = !vo_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign s_fire   = s_tvalid && ready1;

    cdcb_date_next u_date_next (
        .cur        (date_reg),
        .operation  (s_tuser[0]),
        .load_year  (s_tdata[13:0]),
        .load_month (s_tdata[17:14]),
        .load_day   (s_tdata[22:18]),
        .nxt        (date_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_reg.year  <= RESET_YEAR;
            date_reg.month <= RESET_MONTH;
            date_reg.day   <= RESET_DAY;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            vo_reg         <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                date_reg <= date_next;
            end
            if (ready1)
            begin
                v1_reg <= s_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                vo_reg <= v2_reg;
            end
        end
    end

    always_comb
    begin
        q100_prod = 27'(date_reg.year) * 27'd5243;
        mt_next   = (date_reg.month >= 4'd10);
        mo_next   = mt_next ? date_reg.month - 4'd10 : date_reg.month;
        if (date_reg.day >= 5'd30)
        begin
            dt_next = 2'd3;
            do_next = 4'(date_reg.day - 5'd30);
        end
        else if (date_reg.day >= 5'd20)
        begin
            dt_next = 2'd2;
            do_next = 4'(date_reg.day - 5'd20);
        end
        else if (date_reg.day >= 5'd10)
        begin
            dt_next = 2'd1;
            do_next = 4'(date_reg.day - 5'd10);
        end
        else
        begin
            dt_next = 2'd0;
            do_next = date_reg.day[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            s2_date_reg <= date_reg;
            s2_q100_reg <= q100_prod[25:19];
            s2_mt_reg   <= mt_next;
            s2_mo_reg   <= mo_next;
            s2_dt_reg   <= dt_next;
            s2_do_reg   <= do_next;
        end
    end

    always_comb
    begin
        lo_diff  = s2_date_reg.year - 14'(s2_q100_reg) * 14'd100;
        lo_next  = lo_diff[6:0];
        yt_next  = div10_99(lo_next);
        yth_next = div10_99(s2_q100_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            o_date_reg <= s2_date_reg;
            o_yth_reg  <= yth_next;
            o_yh_reg   <= 4'(s2_q100_reg - 7'(yth_next) * 7'd10);
            o_yt_reg   <= yt_next;
            o_yo_reg   <= 4'(lo_next - 7'(yt_next) * 7'd10);
            o_mt_reg   <= s2_mt_reg;
            o_mo_reg   <= s2_mo_reg;
            o_dt_reg   <= s2_dt_reg;
            o_do_reg   <= s2_do_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {6'd0, o_do_reg, o_dt_reg, o_mo_reg, o_mt_reg, o_yo_reg, o_yt_reg,
                       o_yh_reg, o_yth_reg, o_date_reg.day, o_date_reg.month,
                       o_date_reg.year};

    `ASSERT_CLK(a_month_range, (date_reg.month >= 4'd1 && date_reg.month <= MONTH_LAST),
        "Stored month is out of range.")
    `ASSERT_CLK(a_day_range,
        (date_reg.day >= 5'd1 && date_reg.day <= month_length(date_reg.year, date_reg.month)),
        "Stored day is outside the month.")
    `ASSERT_IMPL(a_tick_step, (s_fire && s_tuser[0] == OP_TICK),
        (date_reg.day == 5'd1 || date_reg.day == $past(date_reg.day) + 5'd1),
        "A tick did not advance the day by one.")
    `ASSERT_CLK(a_out_digits, (!vo_reg || (o_yo_reg <= 4'd9 && o_yt_reg <= 4'd9 &&
        o_yh_reg <= 4'd9 && o_yth_reg <= 4'd9)),
        "Year digit out of decimal range.")

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Calendar date counter testbench
// Drives tick and load transactions into the date counter, from a directed
// table of calendar corner cases and then from random date sequences. It
// predicts each date and its YYYYMMDD digits and checks every output
// transaction, with random idle cycles and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb;
    import cdcb_pkg::*;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BLOCKS = 35;
    localparam int BLOCK_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_LIMIT   = 4000;

    // Same layout as the low bits of m_tdata, year in the lowest bits.
    typedef struct packed {
        logic [3:0]         day_ones;
        logic [1:0]         day_tens;
        logic [3:0]         mon_ones;
        logic               mon_tens;
        logic [3:0]         yr_ones;
        logic [3:0]         yr_tens;
        logic [3:0]         yr_hund;
        logic [3:0]         yr_thou;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_readout_t;

    typedef struct packed {
        logic               op;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               typed;
        date_t              want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    logic          typed_now;
    date_t         typed_date;
    date_t         cal_now = '{RESET_YEAR, RESET_MONTH, RESET_DAY};
    date_readout_t readout_q[$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            hold_asked = 0;
    int            hold_done = 0;

    // The year wraps, out-of-range load fields are corrected, and the load
    // fields of a tick transaction carry garbage that must be ignored.
    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b1, '{14'd2022, 4'd1,  5'd2}},
        '{OP_LOAD, 14'd9999,  4'd12, 5'd31, 1'b1, '{14'd9999, 4'd12, 5'd31}},
        '{OP_TICK, 14'd16383, 4'd15, 5'd31, 1'b1, '{14'd0,    4'd1,  5'd1}},
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b1, '{14'd0,    4'd1,  5'd2}},
        '{OP_LOAD, 14'd16383, 4'd15, 5'd31, 1'b1, '{14'd9999, 4'd1,  5'd31}},
        '{OP_LOAD, 14'd0,     4'd0,  5'd0,  1'b1, '{14'd0,    4'd1,  5'd1}},
        '{OP_LOAD, 14'd2023,  4'd2,  5'd29, 1'b1, '{14'd2023, 4'd2,  5'd1}},
        '{OP_LOAD, 14'd2024,  4'd2,  5'd29, 1'b1, '{14'd2024, 4'd2,  5'd29}},
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b1, '{14'd2024, 4'd3,  5'd1}},
        '{OP_LOAD, 14'd2024,  4'd2,  5'd30, 1'b1, '{14'd2024, 4'd2,  5'd1}},
        '{OP_LOAD, 14'd2023,  4'd2,  5'd28, 1'b0, '0},
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_LOAD, 14'd2021,  4'd4,  5'd31, 1'b1, '{14'd2021, 4'd4,  5'd1}},
        '{OP_LOAD, 14'd2021,  4'd4,  5'd30, 1'b0, '0},
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_LOAD, 14'd1999,  4'd13, 5'd15, 1'b1, '{14'd1999, 4'd1,  5'd15}},
        '{OP_LOAD, 14'd1999,  4'd14, 5'd31, 1'b1, '{14'd1999, 4'd1,  5'd31}},
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_LOAD, 14'd2000,  4'd12, 5'd31, 1'b0, '0},
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b1, '{14'd2001, 4'd1,  5'd1}},
        '{OP_LOAD, 14'd1234,  4'd10, 5'd19, 1'b0, '0},
        '{OP_TICK, 14'd5555,  4'd7,  5'd21, 1'b0, '0},
        '{OP_LOAD, 14'd5678,  4'd11, 5'd30, 1'b0, '0},
        '{OP_TICK, 14'd0,     4'd0,  5'd0,  1'b0, '0},
        '{OP_LOAD, 14'd8192,  4'd0,  5'd0,  1'b1, '{14'd8192, 4'd1,  5'd1}}
    };

    calendar_date_counter_bcd_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [YEAR_W-1:0] y,
                                                       input logic [MONTH_W-1:0] m);
        case (m)
            4'd2:                    return (y % 4 == 0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return 5'd31;
        endcase
    endfunction

    function automatic date_t calendar_after(input logic op, input logic [YEAR_W-1:0] y,
                                             input logic [MONTH_W-1:0] m,
                                             input logic [DAY_W-1:0] d);
        date_t nd;
        nd = cal_now;
        if (op == OP_LOAD) begin
            nd.year  = (y > YEAR_LAST) ? YEAR_LAST : y;
            nd.month = (m == 4'd0 || m > MONTH_LAST) ? 4'd1 : m;
            nd.day   = (d == 5'd0 || d > days_in_month(nd.year, nd.month)) ? 5'd1 : d;
        end
        else if (cal_now.day < days_in_month(cal_now.year, cal_now.month)) begin
            nd.day = cal_now.day + 5'd1;
        end
        else begin
            nd.day = 5'd1;
            if (cal_now.month < MONTH_LAST) begin
                nd.month = cal_now.month + 4'd1;
            end
            else begin
                nd.month = 4'd1;
                nd.year  = (cal_now.year >= YEAR_LAST) ? '0 : cal_now.year + 14'd1;
            end
        end
        return nd;
    endfunction

    function automatic date_readout_t date_readout(input date_t dt);
        date_readout_t r;
        int            yr;
        int            mo;
        int            dy;
        yr = int'(dt.year);
        mo = int'(dt.month);
        dy = int'(dt.day);
        r.year     = dt.year;
        r.month    = dt.month;
        r.day      = dt.day;
        r.yr_thou  = 4'(yr / 1000);
        r.yr_hund  = 4'((yr % 1000) / 100);
        r.yr_tens  = 4'((yr % 100) / 10);
        r.yr_ones  = 4'(yr % 10);
        r.mon_tens = 1'(mo / 10);
        r.mon_ones = 4'(mo % 10);
        r.day_tens = 2'(dy / 10);
        r.day_ones = 4'(dy % 10);
        return r;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [YEAR_W-1:0] pick_year();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 14'($urandom_range(9990, 9999));
        if (r < 35) return 14'(4 * $urandom_range(0, 2499));
        return 14'($urandom_range(0, 9999));
    endfunction

    function void note_failure(input string msg);
        if (mismatch_count < 10) $display("%s", msg);
        mismatch_count++;
    endfunction

    function void cmp_field(input string field, input logic [13:0] want_v,
                            input logic [13:0] got_v);
        if (got_v !== want_v)
            note_failure($sformatf("Result %0d, %s: expected %0d, got %0d",
                                   results_seen, field, want_v, got_v));
    endfunction

    task automatic offer(input logic op, input logic [YEAR_W-1:0] y,
                         input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                         input logic typed, input date_t want, input bit gaps);
        int gap;
        gap = gaps ? idle_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= {1'b0, d, m, y};
        typed_now  <= typed;
        typed_date <= want;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    always @(posedge clk) begin : monitor
        date_readout_t want;
        date_readout_t got;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                cal_now = calendar_after(s_tuser[0], s_tdata[13:0], s_tdata[17:14],
                                         s_tdata[22:18]);
                readout_q.push_back(date_readout(typed_now ? typed_date : cal_now));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[49:0];
                if (readout_q.size() == 0) begin
                    note_failure($sformatf("Result %0d arrived with no transaction behind it",
                                           results_seen));
                end
                else begin
                    want = readout_q.pop_front();
                    cmp_field("year_now", want.year, got.year);
                    cmp_field("month_now", want.month, got.month);
                    cmp_field("day_now", want.day, got.day);
                    cmp_field("digit_year_thousands", want.yr_thou, got.yr_thou);
                    cmp_field("digit_year_hundreds", want.yr_hund, got.yr_hund);
                    cmp_field("digit_year_tens", want.yr_tens, got.yr_tens);
                    cmp_field("digit_year_ones", want.yr_ones, got.yr_ones);
                    cmp_field("digit_month_tens", want.mon_tens, got.mon_tens);
                    cmp_field("digit_month_ones", want.mon_ones, got.mon_ones);
                    cmp_field("digit_day_tens", want.day_tens, got.day_tens);
                    cmp_field("digit_day_ones", want.day_ones, got.day_ones);
                end
                results_seen++;
            end
        end
    end

    initial begin : receiver
        int run;
        int gap;
        m_tready <= 1'b0;
        wait (rst_n);
        forever begin
            if (hold_asked != hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end
            run = $urandom_range(1, 30);
            m_tready <= 1'b1;
            @(posedge clk);
            for (int k = 1; k < run && hold_asked == hold_done; k++) @(posedge clk);
            gap = idle_gap();
            if (gap > 0 && hold_asked == hold_done) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic               op;
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        logic [DAY_W-1:0]   lim;
        int                 r;
        bit                 gaps;
        int                 waited;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= OP_TICK;
        typed_now  <= 1'b0;
        typed_date <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].op, directed_rows[i].year, directed_rows[i].month,
                  directed_rows[i].day, directed_rows[i].typed, directed_rows[i].want, 1'b1);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (readout_q.size() != 0) @(posedge clk);

        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            // The receiver stalls for a long stretch while input keeps coming.
            if (blk == 3 || blk == 20) hold_asked <= hold_asked + 1;
            gaps = !(blk % 5 == 4 || blk == 3 || blk == 20);
            if (blk == 12 || blk == 27) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (readout_q.size() != 0) @(posedge clk);
            end
            for (int i = 0; i < BLOCK_ITEMS; i++) begin
                r   = $urandom_range(0, 99);
                op  = OP_LOAD;
                y   = pick_year();
                m   = 4'($urandom_range(1, 12));
                lim = days_in_month(y, m);
                if (r < 55) begin
                    op = OP_TICK;
                    y  = 14'($urandom_range(0, 16383));
                    m  = 4'($urandom_range(0, 15));
                    d  = 5'($urandom_range(0, 31));
                end
                else if (r < 80) begin
                    if ($urandom_range(0, 4) == 0) begin
                        m   = 4'd12;
                        lim = 5'd31;
                    end
                    d = lim - 5'($urandom_range(0, 2));
                end
                else if (r < 90) begin
                    d = 5'($urandom_range(1, lim));
                end
                else begin
                    y = 14'($urandom_range(0, 16383));
                    m = 4'($urandom_range(0, 15));
                    d = 5'($urandom_range(0, 31));
                end
                offer(op, y, m, d, 1'b0, '0, gaps);
            end
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (readout_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (readout_q.size() != 0)
            note_failure($sformatf("%0d expected results never arrived", readout_q.size()));
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
